// ----- rtl/fb64d_pkg.sv -----
// ----------------------------------------------------------------------------
// fb64d_pkg
// Shared types, constants and the character classifier of the forgiving
// base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fb64d_pkg;

  // Queue between classifier and decode back end
  localparam int unsigned QueueDepthDefault = 4;

  // Whitespace characters that are skipped
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;

  // Letter value bases
  localparam logic [5:0] BaseLower = 6'd26;
  localparam logic [5:0] BaseDigit = 6'd52;
  localparam logic [5:0] ValPlus   = 6'd62;
  localparam logic [5:0] ValSlash  = 6'd63;

  // Kind of one input character
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_SPACE = 2'd1,
    KIND_PAD   = 2'd2,
    KIND_BAD   = 2'd3
  } char_kind_e;

  // Classified word passed from front to back
  typedef struct packed {
    char_kind_e kind;
    logic [5:0] value;
    logic       last;
  } item_t;

  // Map a raw byte to its kind and 6-bit letter value
  function automatic item_t classify(input logic [7:0] c, input logic last);
    item_t      it;
    logic [7:0] off;
    it.kind  = KIND_BAD;
    it.value = 6'd0;
    it.last  = last;
    off      = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      off      = c - 8'h41;
      it.kind  = KIND_DATA;
      it.value = off[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      off      = c - 8'h61;
      it.kind  = KIND_DATA;
      it.value = off[5:0] + BaseLower;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off      = c - 8'h30;
      it.kind  = KIND_DATA;
      it.value = off[5:0] + BaseDigit;
    end else if (c == 8'h2B) begin
      it.kind  = KIND_DATA;
      it.value = ValPlus;
    end else if (c == 8'h2F) begin
      it.kind  = KIND_DATA;
      it.value = ValSlash;
    end else if (c == CharTab || c == CharLf || c == CharFf || c == CharCr ||
                 c == CharSpace) begin
      it.kind  = KIND_SPACE;
    end else if (c == 8'h3D) begin
      it.kind  = KIND_PAD;
    end
    return it;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fb64d_front.sv -----
// ----------------------------------------------------------------------------
// fb64d_front
// Accepts character words and classifies them into kind and letter value.
// ----------------------------------------------------------------------------
`default_nettype none

module fb64d_front
  import fb64d_pkg::*;
(
  input  wire logic  s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] in_char
  input  wire logic  s_axis_tlast,       // last
  output logic       push_o,
  output item_t      item_o,
  input  wire logic  full_i
);

  // Accept whenever the queue has room
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // Character classification
  always_comb begin
    item_o = classify(s_axis_tdata, s_axis_tlast);
  end

endmodule

`default_nettype wire

// ----- rtl/fb64d_queue.sv -----
// ----------------------------------------------------------------------------
// fb64d_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fb64d_queue
  import fb64d_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fb64d_back.sv -----
// ----------------------------------------------------------------------------
// fb64d_back
// Decode back end: bit packing, pad and length checks, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fb64d_back
  import fb64d_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  wire logic  m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] error
  output logic       m_axis_tlast    // message_end
);

  logic [5:0]  bits_q, bits_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  pad_q, pad_d;
  logic        failed_q, failed_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  out_user_q;
  logic        out_last_q;

  logic        pop;
  logic        have_byte;
  logic [7:0]  byte_val;
  logic        err;
  logic        res;
  logic [11:0] comb;
  logic [11:0] shifted;
  logic [2:0]  ncnt;
  logic [1:0]  len_sum;

  // Advance when the output register is free or being drained
  assign pop   = item_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o = pop;

  // State update for one classified word
  always_comb begin
    bits_d    = bits_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    pad_d     = pad_q;
    failed_d  = failed_q;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    comb      = {bits_q, item_i.value};
    ncnt      = cnt_q - 3'd2;
    shifted   = comb >> ncnt;
    unique case (item_i.kind)
      KIND_DATA: begin
        failed_d = failed_q || (pad_q != 2'd0);
        phase_d  = phase_q + 2'd1;
        if (cnt_q >= 3'd2) begin
          byte_val  = shifted[7:0];
          bits_d    = comb[5:0] & ~(6'h3F << ncnt);
          cnt_d     = ncnt;
          have_byte = !failed_d;
        end else begin
          bits_d = comb[5:0];
          cnt_d  = cnt_q + 3'd6;
        end
      end
      KIND_PAD: begin
        if (pad_q != 2'd3) begin
          pad_d = pad_q + 2'd1;
        end
      end
      KIND_BAD: begin
        failed_d = 1'b1;
      end
      KIND_SPACE: begin
      end
      default: begin
      end
    endcase

    // End-of-message validity
    len_sum = phase_d + pad_d;
    err = failed_d || (pad_d == 2'd3) || ((pad_d != 2'd0) && (len_sum != 2'd0)) ||
          (phase_d == 2'd1);
    res = have_byte || item_i.last;

    // Message end clears everything
    if (item_i.last) begin
      bits_d   = '0;
      cnt_d    = '0;
      phase_d  = '0;
      pad_d    = '0;
      failed_d = 1'b0;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q   <= '0;
      cnt_q    <= '0;
      phase_q  <= '0;
      pad_q    <= '0;
      failed_q <= 1'b0;
    end else if (pop) begin
      bits_q   <= bits_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      pad_q    <= pad_d;
      failed_q <= failed_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && res) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (pop && res) begin
      out_byte_q <= have_byte ? byte_val : 8'd0;
      out_user_q <= {err && item_i.last, have_byte};
      out_last_q <= item_i.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // Error is only flagged on a message end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[1] |-> out_last_q)
    else $error("error flag without message end");

  // Leftover bit count stays even
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_q[0])
    else $error("odd leftover bit count");

  // Message end clears the decoder state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.last |=> (phase_q == 2'd0) && (pad_q == 2'd0) && !failed_q &&
                           (cnt_q == 3'd0))
    else $error("state not cleared after message end");

  // No byte goes out once the message has failed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && have_byte |-> !failed_d)
    else $error("byte emitted on failed message");

endmodule

`default_nettype wire

// ----- rtl/forgiving_base64_decoder_top.sv -----
// ----------------------------------------------------------------------------
// forgiving_base64_decoder_top
// Streaming forgiving base64 decoder with whitespace skipping and checks.
// ----------------------------------------------------------------------------
// One character word is taken per clock cycle while the queue is not full.
// The front classifies each character and drops it into a small queue
// (QueueDepth words); the back end updates the bit packer and the pad/length
// checks for each character and writes any result into an output register,
// so the sustained rate is one character per cycle while the output is not
// stalled. A result passes through the queue and the output register before
// it is offered. A result carries a decoded byte, a message end mark, or
// both; error is valid only with the end mark and then tells the consumer
// to drop the bytes of that message.
`default_nettype none

module forgiving_base64_decoder_top
  import fb64d_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tlast,   // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] error
  output logic            m_axis_tlast    // message_end
);

  logic  push;
  logic  full;
  logic  q_valid;
  logic  pop;
  item_t front_item;
  item_t q_item;

  fb64d_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  fb64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  fb64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
